>>> rtl/tusq_pkg.sv
// Shared types, widths and helper functions for the triangle/unit-square overlap test.
package tusq_pkg;

    localparam int COORD_W    = 20;
    localparam int PROD_W     = 2*COORD_W + 2;
    localparam int AREA_W     = 2*COORD_W + 3;
    localparam int SUM_W      = AREA_W + 1;
    localparam int VTX_W      = COORD_W + 3;
    localparam int TOL_W      = 10;
    localparam int NUM_STAGES = 5;
    localparam int NUM_EDGES  = 3;
    localparam int NUM_CORNERS = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0]   delta_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [AREA_W-1:0]  area_t;
    typedef logic [SUM_W-1:0]          asum_t;
    typedef logic [SUM_W+TOL_W-1:0]    tol_t;

    // Load enables, one per pipeline stage
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    function automatic asum_t area_mag(input area_t v);
        area_t m;
        m = v[AREA_W-1] ? -v : v;
        return {1'b0, $unsigned(m)};
    endfunction

    // x * 1000 as 1024x - 16x - 8x
    function automatic tol_t times_tol(input asum_t d);
        tol_t w;
        w = {{TOL_W{1'b0}}, d};
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

>>> rtl/tusq_pipe_ctrl.sv
// Valid bits and per-stage load enables for the overlap test pipeline.
module tusq_pipe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output tusq_pkg::stage_en_t en
);
    import tusq_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    // a stage loads when it is empty or its content moves on this cycle
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES-2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (!ready[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = in_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.s0     = ready[0];
    assign en.s1     = ready[1];
    assign en.s2     = ready[2];
    assign en.s3     = ready[3];
    assign en.s4     = ready[4];
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

>>> rtl/tusq_vertex_test.sv
// Tests each triangle vertex against the two half-square triangles.
module tusq_vertex_test
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                clk,
    input  tusq_pkg::stage_en_t en,
    input  tusq_pkg::coord_t    ax,
    input  tusq_pkg::coord_t    ay,
    input  tusq_pkg::coord_t    bx,
    input  tusq_pkg::coord_t    by,
    input  tusq_pkg::coord_t    cx,
    input  tusq_pkg::coord_t    cy,
    output logic                vtx_hit
);
    import tusq_pkg::*;

    typedef logic signed [VTX_W-1:0] vdist_t;
    typedef logic [VTX_W-1:0]        vmag_t;

    localparam vdist_t ONE = vdist_t'(1) <<< FRAC_BITS;

    function automatic vmag_t vmag(input vdist_t v);
        vdist_t m;
        m = v[VTX_W-1] ? -v : v;
        return $unsigned(m);
    endfunction

    vdist_t px [NUM_EDGES];
    vdist_t py [NUM_EDGES];
    vmag_t  dev_a_next [NUM_EDGES];
    vmag_t  dev_b_next [NUM_EDGES];
    vmag_t  dev_a_reg  [NUM_EDGES];
    vmag_t  dev_b_reg  [NUM_EDGES];
    logic   hit_next;
    logic   hit_s2_reg;
    logic   hit_s3_reg;

    // With reference area ONE^2 every sub-area carries a factor ONE, so the
    // test reduces to 1000 * (T - ONE) < ONE on the scaled sum T.
    always_comb
    begin
        px[0] = vdist_t'(ax);
        py[0] = vdist_t'(ay);
        px[1] = vdist_t'(bx);
        py[1] = vdist_t'(by);
        px[2] = vdist_t'(cx);
        py[2] = vdist_t'(cy);
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            // (0,0)(1,1)(0,1)
            dev_a_next[i] = vmag(px[i] - py[i]) + vmag(py[i] - ONE) + vmag(px[i])
                            - vmag_t'(ONE);
            // (0,0)(1,0)(1,1)
            dev_b_next[i] = vmag(py[i]) + vmag(px[i] - ONE) + vmag(px[i] - py[i])
                            - vmag_t'(ONE);
        end
    end

    always_comb
    begin
        hit_next = 1'b0;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            if (times_tol(asum_t'(dev_a_reg[i])) < tol_t'(ONE))
            begin
                hit_next = 1'b1;
            end
            if (times_tol(asum_t'(dev_b_reg[i])) < tol_t'(ONE))
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            dev_a_reg <= dev_a_next;
            dev_b_reg <= dev_b_next;
        end
        if (en.s2)
        begin
            hit_s2_reg <= hit_next;
        end
        if (en.s3)
        begin
            hit_s3_reg <= hit_s2_reg;
        end
    end

    assign vtx_hit = hit_s3_reg;

endmodule

>>> rtl/tusq_edge_area.sv
// Edge cross products and the triangle's doubled area.
module tusq_edge_area
(
    input  logic                clk,
    input  tusq_pkg::stage_en_t en,
    input  tusq_pkg::coord_t    ax,
    input  tusq_pkg::coord_t    ay,
    input  tusq_pkg::coord_t    bx,
    input  tusq_pkg::coord_t    by,
    input  tusq_pkg::coord_t    cx,
    input  tusq_pkg::coord_t    cy,
    output tusq_pkg::area_t     edge_c0 [tusq_pkg::NUM_EDGES],
    output tusq_pkg::delta_t    edge_dx [tusq_pkg::NUM_EDGES],
    output tusq_pkg::delta_t    edge_dy [tusq_pkg::NUM_EDGES],
    output tusq_pkg::asum_t     ref_area
);
    import tusq_pkg::*;

    coord_t x0 [NUM_EDGES];
    coord_t y0 [NUM_EDGES];
    coord_t x1 [NUM_EDGES];
    coord_t y1 [NUM_EDGES];
    delta_t dx_next [NUM_EDGES];
    delta_t dy_next [NUM_EDGES];
    prod_t  py_next [NUM_EDGES];
    prod_t  px_next [NUM_EDGES];
    prod_t  r1_next;
    prod_t  r2_next;

    delta_t dx_s1_reg [NUM_EDGES];
    delta_t dy_s1_reg [NUM_EDGES];
    prod_t  py_reg    [NUM_EDGES];
    prod_t  px_reg    [NUM_EDGES];
    prod_t  r1_reg;
    prod_t  r2_reg;

    area_t  c0_next  [NUM_EDGES];
    area_t  c0_reg   [NUM_EDGES];
    delta_t dx_s2_reg [NUM_EDGES];
    delta_t dy_s2_reg [NUM_EDGES];
    asum_t  ref_reg;

    // edges A->B, B->C, C->A; c0 = y0*dx - x0*dy is the cross term at the origin
    always_comb
    begin
        x0[0] = ax; y0[0] = ay; x1[0] = bx; y1[0] = by;
        x0[1] = bx; y0[1] = by; x1[1] = cx; y1[1] = cy;
        x0[2] = cx; y0[2] = cy; x1[2] = ax; y1[2] = ay;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            dx_next[e] = delta_t'(x1[e]) - delta_t'(x0[e]);
            dy_next[e] = delta_t'(y1[e]) - delta_t'(y0[e]);
            py_next[e] = y0[e] * dx_next[e];
            px_next[e] = x0[e] * dy_next[e];
        end
        r1_next = dx_next[2] * dy_next[0];
        r2_next = dy_next[2] * dx_next[0];
    end

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            c0_next[e] = area_t'(py_reg[e]) - area_t'(px_reg[e]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            dx_s1_reg <= dx_next;
            dy_s1_reg <= dy_next;
            py_reg    <= py_next;
            px_reg    <= px_next;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
        end
        if (en.s2)
        begin
            c0_reg    <= c0_next;
            dx_s2_reg <= dx_s1_reg;
            dy_s2_reg <= dy_s1_reg;
            ref_reg   <= area_mag(area_t'(r2_reg) - area_t'(r1_reg));
        end
    end

    assign edge_c0  = c0_reg;
    assign edge_dx  = dx_s2_reg;
    assign edge_dy  = dy_s2_reg;
    assign ref_area = ref_reg;

endmodule

>>> rtl/tusq_corner_sum.sv
// Area-sum excess of each unit-square corner over the triangle's area.
module tusq_corner_sum
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                clk,
    input  tusq_pkg::stage_en_t en,
    input  tusq_pkg::area_t     edge_c0 [tusq_pkg::NUM_EDGES],
    input  tusq_pkg::delta_t    edge_dx [tusq_pkg::NUM_EDGES],
    input  tusq_pkg::delta_t    edge_dy [tusq_pkg::NUM_EDGES],
    input  tusq_pkg::asum_t     ref_area,
    output tusq_pkg::asum_t     excess [tusq_pkg::NUM_CORNERS],
    output tusq_pkg::asum_t     ref_out
);
    import tusq_pkg::*;

    area_t dx_one [NUM_EDGES];
    area_t dy_one [NUM_EDGES];
    area_t sub    [NUM_CORNERS][NUM_EDGES];
    asum_t total  [NUM_CORNERS];
    asum_t excess_next [NUM_CORNERS];
    asum_t excess_reg  [NUM_CORNERS];
    asum_t ref_reg;

    // corner k sits at (k[1], k[0]) in units of one; sub-area is
    // c0 + x*dy - y*dx. The sum never falls below the triangle's area.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            dx_one[e] = area_t'(edge_dx[e]) <<< FRAC_BITS;
            dy_one[e] = area_t'(edge_dy[e]) <<< FRAC_BITS;
        end
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            total[k] = '0;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                sub[k][e] = edge_c0[e];
                if (k[1])
                begin
                    sub[k][e] = sub[k][e] + dy_one[e];
                end
                if (k[0])
                begin
                    sub[k][e] = sub[k][e] - dx_one[e];
                end
                total[k] = total[k] + area_mag(sub[k][e]);
            end
            excess_next[k] = total[k] - ref_area;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            excess_reg <= excess_next;
            ref_reg    <= ref_area;
        end
    end

    assign excess  = excess_reg;
    assign ref_out = ref_reg;

endmodule

>>> rtl/triangle_unit_square_overlap_test.sv
// Top level: triangle versus unit screen square overlap test.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+---------------------------
//   in      | input     | in_valid / in_stall  | ax ay bx by cx cy (Q8.12)
//   out     | output    | out_valid / out_stall| overlaps
//
// Five register stages: input, products, areas, corner excess, result.
// An item moves through the stages in order and shows on out_valid from the
// result stage; one item per cycle while out_stall does not hold the flow.
// Reset clears only the valid bits; nothing else needs clearing.
// A stall on out holds the result; earlier empty stages keep filling, so
// in_stall rises only once all five stages hold items.
module triangle_unit_square_overlap_test
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tusq_pkg::coord_t ax,
    input  tusq_pkg::coord_t ay,
    input  tusq_pkg::coord_t bx,
    input  tusq_pkg::coord_t by,
    input  tusq_pkg::coord_t cx,
    input  tusq_pkg::coord_t cy,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             overlaps
);
    import tusq_pkg::*;

    stage_en_t en;

    coord_t ax_reg;
    coord_t ay_reg;
    coord_t bx_reg;
    coord_t by_reg;
    coord_t cx_reg;
    coord_t cy_reg;

    area_t  edge_c0 [NUM_EDGES];
    delta_t edge_dx [NUM_EDGES];
    delta_t edge_dy [NUM_EDGES];
    asum_t  ref_area;
    asum_t  excess [NUM_CORNERS];
    asum_t  ref_s3;
    logic   vtx_hit;
    logic   overlaps_next;
    logic   overlaps_reg;

    tusq_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .en        (en)
    );

    always_ff @(posedge clk)
    begin
        if (en.s0)
        begin
            ax_reg <= ax;
            ay_reg <= ay;
            bx_reg <= bx;
            by_reg <= by;
            cx_reg <= cx;
            cy_reg <= cy;
        end
    end

    tusq_vertex_test #(.FRAC_BITS(FRAC_BITS)) u_vertex
    (
        .clk     (clk),
        .en      (en),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .bx      (bx_reg),
        .by      (by_reg),
        .cx      (cx_reg),
        .cy      (cy_reg),
        .vtx_hit (vtx_hit)
    );

    tusq_edge_area u_edge
    (
        .clk      (clk),
        .en       (en),
        .ax       (ax_reg),
        .ay       (ay_reg),
        .bx       (bx_reg),
        .by       (by_reg),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .edge_c0  (edge_c0),
        .edge_dx  (edge_dx),
        .edge_dy  (edge_dy),
        .ref_area (ref_area)
    );

    tusq_corner_sum #(.FRAC_BITS(FRAC_BITS)) u_corner
    (
        .clk      (clk),
        .en       (en),
        .edge_c0  (edge_c0),
        .edge_dx  (edge_dx),
        .edge_dy  (edge_dy),
        .ref_area (ref_area),
        .excess   (excess),
        .ref_out  (ref_s3)
    );

    // inside when 1000 * excess < area; a zero-area triangle never passes
    always_comb
    begin
        overlaps_next = vtx_hit;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            if (times_tol(excess[k]) < tol_t'(ref_s3))
            begin
                overlaps_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            overlaps_reg <= overlaps_next;
        end
    end

    assign overlaps = overlaps_reg;

endmodule

>>> rtl/tusq_checker.sv
// Port-level checks for the overlap test, bound to the top level.
module tusq_checker
#(
    parameter int FRAC_BITS = 12
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input tusq_pkg::coord_t ax,
    input tusq_pkg::coord_t ay,
    input logic             out_valid,
    input logic             out_stall,
    input logic             overlaps
);
    import tusq_pkg::*;

    // (1/2, 1/4) lies inside the lower-right half square
    localparam coord_t PT_X = coord_t'(1) <<< (FRAC_BITS - 1);
    localparam coord_t PT_Y = coord_t'(1) <<< (FRAC_BITS - 2);

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(overlaps))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown right after reset");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("item did not reach output in five cycles");

    a_vertex_hit: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && ax == PT_X && ay == PT_Y && !out_stall ##1 !out_stall
        ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid && overlaps)
        else $error("vertex inside square not reported");

endmodule

bind triangle_unit_square_overlap_test tusq_checker #(.FRAC_BITS(FRAC_BITS)) u_tusq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ax        (ax),
    .ay        (ay),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .overlaps  (overlaps)
);
